// ----- src/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the matrix to quaternion converter
// branch codes, component select and the word carried along the cell chain
// ----------------------------------------------------------------------------
package rmq_pkg;

	localparam int DW = 16;

	localparam logic [1:0] BR_X = 2'd0;
	localparam logic [1:0] BR_Y = 2'd1;
	localparam logic [1:0] BR_Z = 2'd2;
	localparam logic [1:0] BR_W = 2'd3;

	typedef logic signed [DW-1:0] sample_t;

	// quotient numerators for the three non-root components, in x, y, z, w
	// order with the root slot unused
	typedef struct packed {
		logic [1:0] branch;
		logic       degen;
		logic signed [DW+1:0] num_x;
		logic signed [DW+1:0] num_y;
		logic signed [DW+1:0] num_z;
		logic signed [DW+1:0] num_w;
	} ctl_t;

	function automatic logic signed [DW-1:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) begin
			return 16'sh7fff;
		end else if (v < -64'sd32768) begin
			return 16'sh8000;
		end
		return v[DW-1:0];
	endfunction

endpackage

// ----- src/rotation_matrix_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: fixed-point rotation matrix to quaternion
// pipelined chain of square-root cells followed by a chain of division cells
// ----------------------------------------------------------------------------
// channel | direction | handshake        | payload
// in      | input     | in_valid/in_stall | r00 .. r22
// out     | output    | out_valid/out_stall | quat_x .. quat_w, degenerate
//
// one transaction per cycle sustained while the output is not stalled; the pipeline is
// the branch and root-argument register, the square-root cell chain (one root bit
// per cell), the division cell chain (one quotient bit per cell) and the output register
// arst_n clears only the valid bits of the pipeline
// a stall on a valid output freezes the whole chain; the input stalls with it
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  rmq_pkg::sample_t r00, r01, r02, r10, r11, r12, r20, r21, r22,
	output logic out_valid,
	input  logic out_stall,
	output rmq_pkg::sample_t quat_x, quat_y, quat_z, quat_w,
	output logic degenerate
);
	import rmq_pkg::*;

	// signed root argument: two bits above the wider of the unit and the
	// three-entry diagonal sum; the radicand is that shifted by FRAC_BITS
	localparam int AW  = (FRAC_BITS > 17 ? FRAC_BITS : 17) + 2;
	localparam int RW  = (AW + FRAC_BITS + 1) / 2;
	localparam int NW  = 18 + FRAC_BITS;
	localparam int LAT = 1 + RW + NW;

	logic en;
	logic [LAT:0] vld_q;

	// a stall holds every stage, so the pipe is a single enable domain
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:0], in_valid};
		end
	end
	assign out_valid = vld_q[LAT];

	// ---------------- stage 1: branch select and root argument
	logic signed [AW-1:0] a00, a11, a22, trace, one_v, arg;
	logic [1:0] br;
	ctl_t ctl_in, ctl_s1;
	logic [2*RW-1:0] rad_s1;

	always_comb begin
		a00 = AW'(r00);
		a11 = AW'(r11);
		a22 = AW'(r22);
		one_v = AW'(1) <<< FRAC_BITS;
		trace = a00 + a11 + a22;
		if (trace > 0) begin
			br = BR_W;
			arg = trace + one_v;
		end else if (a00 > a11 && a00 > a22) begin
			br = BR_X;
			arg = one_v + a00 - a11 - a22;
		end else if (a11 > a22) begin
			br = BR_Y;
			arg = one_v + a11 - a00 - a22;
		end else begin
			br = BR_Z;
			arg = one_v + a22 - a00 - a11;
		end
		ctl_in.branch = br;
		ctl_in.degen = !(arg > 0);
		ctl_in.num_x = '0;
		ctl_in.num_y = '0;
		ctl_in.num_z = '0;
		ctl_in.num_w = '0;
		unique case (br)
			BR_W: begin
				ctl_in.num_x = 18'(r21) - 18'(r12);
				ctl_in.num_y = 18'(r02) - 18'(r20);
				ctl_in.num_z = 18'(r10) - 18'(r01);
			end
			BR_X: begin
				ctl_in.num_w = 18'(r21) - 18'(r12);
				ctl_in.num_y = 18'(r01) + 18'(r10);
				ctl_in.num_z = 18'(r02) + 18'(r20);
			end
			BR_Y: begin
				ctl_in.num_w = 18'(r02) - 18'(r20);
				ctl_in.num_x = 18'(r01) + 18'(r10);
				ctl_in.num_z = 18'(r12) + 18'(r21);
			end
			default: begin
				ctl_in.num_w = 18'(r10) - 18'(r01);
				ctl_in.num_x = 18'(r02) + 18'(r20);
				ctl_in.num_y = 18'(r12) + 18'(r21);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_in;
			rad_s1 <= ctl_in.degen ? '0 : (2*RW)'(arg) << FRAC_BITS;
		end
	end

	// ---------------- square-root cell chain
	logic [2*RW-1:0] sq_rad  [RW+1];
	logic [RW+1:0]   sq_rem  [RW+1];
	logic [RW-1:0]   sq_root [RW+1];
	ctl_t            sq_ctl  [RW+1];

	assign sq_rad[0]  = rad_s1;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_ctl[0]  = ctl_s1;

	for (genvar g = 0; g < RW; g++) begin : g_sq
		rmq_sqrt_cell #(.RW(RW), .STEP(g)) u_cell (
			.clk(clk), .en(en),
			.rad_i(sq_rad[g]), .rem_i(sq_rem[g]), .root_i(sq_root[g]), .ctl_i(sq_ctl[g]),
			.rad_o(sq_rad[g+1]), .rem_o(sq_rem[g+1]), .root_o(sq_root[g+1]),
			.ctl_o(sq_ctl[g+1])
		);
	end

	// ---------------- division cell chain: (|d| << F + root) / (2 root)
	localparam int DVW = RW + 1;
	logic [NW-1:0]  dv_num [NW+1][3];
	logic [DVW:0]   dv_rem [NW+1][3];
	logic [NW-1:0]  dv_quo [NW+1][3];
	logic [DVW-1:0] dv_dvs [NW+1];
	ctl_t           dv_ctl [NW+1];
	logic [DVW-1:0] dv_root [NW+1];
	logic signed [DW+1:0] nsel [3];
	logic [RW-1:0] rt;

	assign rt = sq_root[RW];
	always_comb begin
		unique case (sq_ctl[RW].branch)
			BR_X: begin nsel[0] = sq_ctl[RW].num_w; nsel[1] = sq_ctl[RW].num_y;
				nsel[2] = sq_ctl[RW].num_z; end
			BR_Y: begin nsel[0] = sq_ctl[RW].num_w; nsel[1] = sq_ctl[RW].num_x;
				nsel[2] = sq_ctl[RW].num_z; end
			BR_Z: begin nsel[0] = sq_ctl[RW].num_w; nsel[1] = sq_ctl[RW].num_x;
				nsel[2] = sq_ctl[RW].num_y; end
			default: begin nsel[0] = sq_ctl[RW].num_x; nsel[1] = sq_ctl[RW].num_y;
				nsel[2] = sq_ctl[RW].num_z; end
		endcase
	end

	// magnitude of each numerator, scaled, plus the root for rounding
	for (genvar k = 0; k < 3; k++) begin : g_lane
		assign dv_num[0][k] = (NW'((nsel[k] < 0 ? -nsel[k] : nsel[k]) & 18'h3ffff)
			<< FRAC_BITS) + NW'(rt);
		assign dv_rem[0][k] = '0;
		assign dv_quo[0][k] = '0;
	end
	assign dv_dvs[0]  = {rt, 1'b0};
	assign dv_ctl[0]  = sq_ctl[RW];
	assign dv_root[0] = DVW'(rt);

	for (genvar g = 0; g < NW; g++) begin : g_dv
		rmq_div_cell #(.NW(NW), .DVW(DVW), .STEP(g)) u_cell (
			.clk(clk), .en(en),
			.dvs_i(dv_dvs[g]), .num_i(dv_num[g]), .rem_i(dv_rem[g]), .quo_i(dv_quo[g]),
			.ctl_i(dv_ctl[g]), .root_i(dv_root[g]),
			.dvs_o(dv_dvs[g+1]), .num_o(dv_num[g+1]), .rem_o(dv_rem[g+1]),
			.quo_o(dv_quo[g+1]), .ctl_o(dv_ctl[g+1]), .root_o(dv_root[g+1])
		);
	end

	// ---------------- output: sign, saturation and component placement
	ctl_t fc;
	logic signed [DW-1:0] qv [3];
	logic signed [DW-1:0] half;
	logic signed [DW-1:0] ox, oy, oz, ow;
	logic signed [DW+1:0] sn [3];

	always_comb begin
		fc = dv_ctl[NW];
		unique case (fc.branch)
			BR_X: begin sn[0] = fc.num_w; sn[1] = fc.num_y; sn[2] = fc.num_z; end
			BR_Y: begin sn[0] = fc.num_w; sn[1] = fc.num_x; sn[2] = fc.num_z; end
			BR_Z: begin sn[0] = fc.num_w; sn[1] = fc.num_x; sn[2] = fc.num_y; end
			default: begin sn[0] = fc.num_x; sn[1] = fc.num_y; sn[2] = fc.num_z; end
		endcase
		half = sat16(64'(dv_root[NW] >> 1));
		for (int k = 0; k < 3; k++) begin
			if (fc.degen) begin
				qv[k] = sn[k] > 0 ? 16'sh7fff : (sn[k] < 0 ? 16'sh8000 : 16'sh0000);
			end else if (sn[k] < 0) begin
				qv[k] = sat16(-$signed(64'(dv_quo[NW][k])));
			end else begin
				qv[k] = sat16($signed(64'(dv_quo[NW][k])));
			end
		end
		unique case (fc.branch)
			BR_X: begin ox = half; ow = qv[0]; oy = qv[1]; oz = qv[2]; end
			BR_Y: begin oy = half; ow = qv[0]; ox = qv[1]; oz = qv[2]; end
			BR_Z: begin oz = half; ow = qv[0]; ox = qv[1]; oy = qv[2]; end
			default: begin ow = half; ox = qv[0]; oy = qv[1]; oz = qv[2]; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat_x <= ox;
			quat_y <= oy;
			quat_z <= oz;
			quat_w <= ow;
			degenerate <= fc.degen;
		end
	end

	// a stalled result must not be lost
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped");
	// the input is never stalled while the output moves
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall) else $error("spurious input stall");
	// a degenerate result leaves at least one component at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate && quat_w != 16'sh0000 |-> quat_x == 16'sh0000 ||
		quat_y == 16'sh0000 || quat_z == 16'sh0000) else $error("degenerate root");
endmodule

// ----- src/rmq_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// rmq_sqrt_cell: one restoring square-root step
// resolves one root bit per cell and hands the remainder to the next cell
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
	parameter int RW = 32,
	parameter int STEP = 0
) (
	input  logic          clk,
	input  logic          en,
	input  logic [2*RW-1:0] rad_i,
	input  logic [RW+1:0]   rem_i,
	input  logic [RW-1:0]   root_i,
	input  rmq_pkg::ctl_t   ctl_i,
	output logic [2*RW-1:0] rad_o,
	output logic [RW+1:0]   rem_o,
	output logic [RW-1:0]   root_o,
	output rmq_pkg::ctl_t   ctl_o
);
	import rmq_pkg::*;

	logic [RW+1:0] trial;
	logic [RW+1:0] shifted;

	// bring down the next radicand bit pair
	assign shifted = {rem_i[RW-1:0], rad_i[2*RW-1-2*STEP -: 2]};
	assign trial = {root_i, 2'b01};

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o <= rad_i;
			ctl_o <= ctl_i;
			if (shifted >= trial) begin
				rem_o  <= shifted - trial;
				root_o <= {root_i[RW-2:0], 1'b1};
			end else begin
				rem_o  <= shifted;
				root_o <= {root_i[RW-2:0], 1'b0};
			end
		end
	end
endmodule

// ----- src/rmq_div_cell.sv -----
// ----------------------------------------------------------------------------
// rmq_div_cell: one restoring division step for three quotient lanes
// all lanes share the divisor; one quotient bit per lane per cell
// ----------------------------------------------------------------------------
module rmq_div_cell #(
	parameter int NW = 48,
	parameter int DVW = 32,
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           en,
	input  logic [DVW-1:0] dvs_i,
	input  logic [NW-1:0]  num_i [3],
	input  logic [DVW:0]   rem_i [3],
	input  logic [NW-1:0]  quo_i [3],
	input  rmq_pkg::ctl_t  ctl_i,
	input  logic [DVW-1:0] root_i,
	output logic [DVW-1:0] dvs_o,
	output logic [NW-1:0]  num_o [3],
	output logic [DVW:0]   rem_o [3],
	output logic [NW-1:0]  quo_o [3],
	output rmq_pkg::ctl_t  ctl_o,
	output logic [DVW-1:0] root_o
);
	import rmq_pkg::*;

	logic [DVW+1:0] sh [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sh[k] = {rem_i[k], num_i[k][NW-1-STEP]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_o  <= dvs_i;
			num_o  <= num_i;
			ctl_o  <= ctl_i;
			root_o <= root_i;
			for (int k = 0; k < 3; k++) begin
				if (sh[k] >= {2'b00, dvs_i}) begin
					rem_o[k] <= (DVW+1)'(sh[k] - {2'b00, dvs_i});
					quo_o[k] <= {quo_i[k][NW-2:0], 1'b1};
				end else begin
					rem_o[k] <= sh[k][DVW:0];
					quo_o[k] <= {quo_i[k][NW-2:0], 1'b0};
				end
			end
		end
	end
endmodule

// ----- sim/rmq_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rmq_checker: quaternion predictor and result comparator
// watches both channels, predicts each accepted matrix and checks the output
// ----------------------------------------------------------------------------
module rmq_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_stall,
	input  rmq_pkg::sample_t r00, r01, r02, r10, r11, r12, r20, r21, r22,
	input  logic out_valid,
	input  logic out_stall,
	input  rmq_pkg::sample_t quat_x, quat_y, quat_z, quat_w,
	input  logic degenerate,
	output int   fail_count,
	output int   pending
);

	localparam int FB = 14;

	typedef struct packed {
		logic signed [15:0] x, y, z, w;
		logic               dg;
	} quat_t;

	quat_t expected_quats[$];

	function automatic longint root_of(input longint n);
		longint r, b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [15:0] clamp(input longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	// rounded half away from zero; a zero root saturates by sign
	function automatic logic signed [15:0] divide(input longint d, input longint rt);
		longint m, q;
		if (rt == 0) return (d > 0) ? 16'sh7fff : (d < 0) ? 16'sh8000 : 16'sh0000;
		m = ((d < 0) ? -d : d) << FB;
		q = (m + rt) / (2 * rt);
		return clamp((d < 0) ? -q : q);
	endfunction

	function automatic quat_t predict_quat(input longint a00, a01, a02, a10, a11,
			a12, a20, a21, a22);
		quat_t  q;
		longint tr, arg, rt;
		logic [1:0] br;
		logic signed [15:0] h;
		tr = a00 + a11 + a22;
		if (tr > 0) begin
			br = rmq_pkg::BR_W; arg = tr + (64'sd1 << FB);
		end else if (a00 > a11 && a00 > a22) begin
			br = rmq_pkg::BR_X; arg = (64'sd1 << FB) + a00 - a11 - a22;
		end else if (a11 > a22) begin
			br = rmq_pkg::BR_Y; arg = (64'sd1 << FB) + a11 - a00 - a22;
		end else begin
			br = rmq_pkg::BR_Z; arg = (64'sd1 << FB) + a22 - a00 - a11;
		end
		q.dg = (arg <= 0);
		rt = (arg > 0) ? root_of(arg << FB) : 0;
		h = clamp(rt >> 1);
		case (br)
			rmq_pkg::BR_W: begin
				q.w = h; q.x = divide(a21 - a12, rt);
				q.y = divide(a02 - a20, rt); q.z = divide(a10 - a01, rt);
			end
			rmq_pkg::BR_X: begin
				q.x = h; q.w = divide(a21 - a12, rt);
				q.y = divide(a01 + a10, rt); q.z = divide(a02 + a20, rt);
			end
			rmq_pkg::BR_Y: begin
				q.y = h; q.w = divide(a02 - a20, rt);
				q.x = divide(a01 + a10, rt); q.z = divide(a12 + a21, rt);
			end
			default: begin
				q.z = h; q.w = divide(a10 - a01, rt);
				q.x = divide(a02 + a20, rt); q.y = divide(a12 + a21, rt);
			end
		endcase
		return q;
	endfunction

	initial fail_count = 0;
	assign pending = expected_quats.size();

	always @(posedge clk) begin
		quat_t e;
		if (arst_n && in_valid && !in_stall)
			expected_quats.insert(expected_quats.size(), predict_quat(r00, r01, r02,
				r10, r11, r12, r20, r21, r22));
		if (arst_n && out_valid && !out_stall) begin
			if (expected_quats.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) $display("unexpected result transaction");
			end else begin
				e = expected_quats.pop_front();
				if (e != {quat_x, quat_y, quat_z, quat_w, degenerate}) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch exp x %0d y %0d z %0d w %0d dg %0d / got %0d %0d %0d %0d %0d",
							e.x, e.y, e.z, e.w, e.dg, quat_x, quat_y, quat_z, quat_w,
							degenerate);
				end
			end
		end
	end

endmodule

// ----- sim/tb_rotation_matrix_to_quaternion.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion: regression for the quaternion converter
// directed matrices for every branch and tie case and for extreme entries, then random
// rotations and noise with random gaps on both channels and a long hold-off
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion;

	localparam int ONE      = 16384;
	localparam int N_RAND   = 1330;
	localparam int LATENCY  = 80;    // root chain plus divide chain, with margin
	localparam int WD_MAX   = 20000;
	localparam int HOLD_LEN = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic out_valid;
	logic out_stall = 1'b0;
	logic degenerate;
	rmq_pkg::sample_t r00 = '0, r01 = '0, r02 = '0, r10 = '0, r11 = '0, r12 = '0;
	rmq_pkg::sample_t r20 = '0, r21 = '0, r22 = '0;
	rmq_pkg::sample_t quat_x, quat_y, quat_z, quat_w;
	int fail_count, pending;
	int idle_cycles = 0;
	int stall_cnt = 0;
	bit hold_off = 1'b0;    // set by the sender to request the long receiver stall
	bit hold_seen = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	rotation_matrix_to_quaternion u_top (.*);

	rmq_checker u_chk (.*);

	// pick a gap length: mostly zero, some short, a few long
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 60) return 0;
		if (p < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// offer one matrix and wait until the transaction is accepted; valid stays
	// high into the next offer when there is no gap
	task automatic send_matrix(input logic [15:0] m [9]);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		{r00, r01, r02, r10, r11, r12, r20, r21, r22} <=
			{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// near-rotation matrix: entries within +-1, diagonal set to pick x, y or z unless k is 3
	task automatic rotation_like(output logic [15:0] m [9]);
		int k;
		k = $urandom_range(3);
		for (int i = 0; i < 9; i++) m[i] = 16'($signed($urandom_range(0, 2 * ONE)) - ONE);
		if (k < 3) begin
			m[0] = 16'(-$urandom_range(0, ONE)); m[4] = 16'(-$urandom_range(0, ONE));
			m[8] = 16'(-$urandom_range(0, ONE));
			m[k * 4] = 16'($urandom_range(0, ONE));
		end
	endtask

	// receiver: random stall runs, plus one long hold-off counted here
	always @(posedge clk) begin
		if (hold_off && !hold_seen) begin
			hold_seen <= 1'b1;
			stall_cnt <= HOLD_LEN;
			out_stall <= 1'b1;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(3) == 0) stall_cnt <= gap_len();
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_MAX) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		logic [15:0] m [9];
		logic [15:0] corners [6];
		corners = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'(ONE), 16'(-ONE)};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity and the three half-turns pick each branch
		for (int b = 0; b < 4; b++) begin
			for (int i = 0; i < 9; i++) m[i] = '0;
			m[0] = (b == 0 || b == 3) ? 16'(ONE) : 16'(-ONE);
			m[4] = (b == 1 || b == 3) ? 16'(ONE) : 16'(-ONE);
			m[8] = (b == 2 || b == 3) ? 16'(ONE) : 16'(-ONE);
			send_matrix(m);
		end
		// diagonal ties: y beats x, z beats both
		m = '{16'h0, 16'd100, 16'd200, 16'd300, 16'h0, 16'd50, 16'd7, 16'd9, 16'hc000};
		send_matrix(m);
		m = '{16'hc000, 16'd1, 16'd2, 16'd3, 16'hc000, 16'd5, 16'd6, 16'd7, 16'hc000};
		send_matrix(m);
		// most negative diagonals, root argument still positive; the second matrix has positive, negative, zero numerators
		m = '{16'h8000, 16'd100, 16'hff00, 16'd100, 16'h8000, 16'h0, 16'd256, 16'h0, 16'h8000};
		send_matrix(m);
		m = '{16'h0, 16'h7fff, 16'h8000, 16'h7fff, 16'h0, 16'h7fff, 16'h8000, 16'h8000,
			16'h8000};
		send_matrix(m);
		// negative diagonal entries; the root argument stays positive
		m = '{16'hc000, 16'd4, 16'd4, 16'd4, 16'hc000, 16'd4, 16'd4, 16'd4, 16'h8000};
		send_matrix(m);
		// all extremes, a large trace, and a small trace with large numerators for full-scale quotients
		for (int c = 0; c < 6; c++) begin
			for (int i = 0; i < 9; i++) m[i] = corners[(c + i) % 6];
			send_matrix(m);
		end
		m = '{16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000,
			16'h7fff, 16'h7fff};
		send_matrix(m);
		m = '{16'd1, 16'h7fff, 16'h8000, 16'h8000, 16'h0, 16'h7fff, 16'h7fff, 16'h8000,
			16'h0};
		send_matrix(m);

		for (int n = 0; n < N_RAND; n++) begin
			// the sender keeps offering through the hold-off so the pipe fills
			if (n == 300) hold_off = 1'b1;
			if (n == 700) begin
				// sender pause until the pipeline drains
				in_valid <= 1'b0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if ($urandom_range(99) < 70) rotation_like(m);
			else for (int i = 0; i < 9; i++) m[i] = 16'($urandom_range(0, 16'hffff));
			send_matrix(m);
		end
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/rmq_pkg.sv
src/rmq_sqrt_cell.sv
src/rmq_div_cell.sv
src/rotation_matrix_to_quaternion.sv
sim/rmq_checker.sv
sim/tb_rotation_matrix_to_quaternion.sv
